@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CSDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a consequent follows an antecedent in the same cycle.
`define CSDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a consequent follows an antecedent in the next cycle.
`define CSDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/csds_pkg.sv @@
// Shared types and constants of the C-SCAN disk scheduler.
package csds_pkg;

  localparam int CYL_W            = 16;
  localparam int MOVE_W           = 18;
  localparam int CFG_W            = 16;
  localparam int CFG_IDX_W        = 1;
  localparam int MAX_REQUESTS_DEF = 32;
  localparam int CYL_BITS_DEF     = 16;
  localparam logic [CFG_W-1:0] MAX_CYL_RESET = 16'd199;

  localparam logic [CFG_IDX_W-1:0] REG_START_POSITION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CYLINDER   = 1'b1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN_HI,
    ST_TOP,
    ST_ZERO,
    ST_SCAN_LO
  } state_e;

  typedef struct packed {
    logic insert;
    logic rotate;
    logic clear;
  } cell_ctl_t;

endpackage

@@ hw/rtl/csds_cell.sv @@
// One cell of the sorted request chain.
module csds_cell #(
  parameter int CylBits = csds_pkg::CYL_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  csds_pkg::cell_ctl_t ctl_i,
  input  logic [CylBits-1:0] ins_value_i,
  input  logic               prev_valid_i,
  input  logic [CylBits-1:0] prev_value_i,
  input  logic               prev_place_i,
  input  logic               next_valid_i,
  input  logic [CylBits-1:0] next_value_i,
  output logic               valid_o,
  output logic [CylBits-1:0] value_o,
  output logic               place_o
);
  import csds_pkg::*;

  logic               valid_q, valid_d;
  logic [CylBits-1:0] value_q, value_d;
  logic               place;

  // The new item lands in the first cell that is empty or holds a larger value.
  assign place = !valid_q || (value_q > ins_value_i);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ctl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctl_i.rotate) begin
      valid_d = next_valid_i;
      value_d = next_value_i;
    end else if (ctl_i.insert && place) begin
      if (!prev_place_i) begin
        valid_d = 1'b1;
        value_d = ins_value_i;
      end else begin
        valid_d = prev_valid_i;
        value_d = prev_value_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign place_o = place;

endmodule

@@ hw/rtl/csds_ctrl.sv @@
// Sequencer, travel accumulator and output register of the scheduler.
module csds_ctrl #(
  parameter int MaxRequests = csds_pkg::MAX_REQUESTS_DEF,
  parameter int CylBits     = csds_pkg::CYL_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_accept_i,
  input  logic                        in_last_i,
  input  logic                        full_i,
  output logic                        in_stall_o,
  input  logic [CylBits-1:0]          start_i,
  input  logic [CylBits-1:0]          max_i,
  input  logic                        c0_valid_i,
  input  logic [CylBits-1:0]          c0_value_i,
  input  logic                        c1_valid_i,
  input  logic [CylBits-1:0]          c1_value_i,
  output csds_pkg::cell_ctl_t         ctl_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [csds_pkg::CYL_W-1:0]  position_o,
  output logic [csds_pkg::MOVE_W-1:0] movement_o,
  output logic                        final_res_o
);
  import csds_pkg::*;

  localparam int CntW = (MaxRequests > 1) ? $clog2(MaxRequests) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(MaxRequests - 1);

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CylBits-1:0] head_q, head_d;
  logic [MOVE_W-1:0] travel_q, travel_d;
  logic out_valid_q, out_valid_d;
  logic [CYL_W-1:0] pos_q;
  logic [MOVE_W-1:0] mov_q;
  logic fin_q;

  logic adv, step, qual, fin, load_out, cnt_last, low_next, batch_end;
  logic [CylBits-1:0] target, gap;
  logic [MOVE_W-1:0] travel_next;
  cell_ctl_t ctl;

  assign adv       = !out_valid_q || !out_stall_i;
  assign cnt_last  = (cnt_q == CntLast);
  assign low_next  = c1_valid_i && (c1_value_i <= start_i);
  assign batch_end = in_accept_i && in_last_i;
  assign gap       = (target > head_q) ? (target - head_q) : (head_q - target);
  assign travel_next = travel_q + MOVE_W'(gap);

  // Outputs of the sequencer.
  always_comb begin
    qual   = 1'b0;
    target = '0;
    fin    = 1'b0;
    step   = 1'b0;
    ctl    = '0;
    unique case (state_q)
      ST_LOAD: begin
        ctl.insert = in_accept_i && !full_i;
      end
      ST_SCAN_HI: begin
        qual       = c0_valid_i && (c0_value_i > start_i);
        target     = c0_value_i;
        step       = qual ? adv : 1'b1;
        ctl.rotate = step;
      end
      ST_TOP: begin
        qual   = 1'b1;
        target = max_i;
        step   = adv;
      end
      ST_ZERO: begin
        qual   = 1'b1;
        target = '0;
        fin    = !(c0_valid_i && (c0_value_i <= start_i));
        step   = adv;
      end
      ST_SCAN_LO: begin
        qual       = c0_valid_i && (c0_value_i <= start_i);
        target     = c0_value_i;
        fin        = !low_next || cnt_last;
        step       = qual ? adv : 1'b1;
        ctl.rotate = step;
        ctl.clear  = step && cnt_last;
      end
      default: begin
        qual = 1'b0;
      end
    endcase
  end

  assign load_out = qual && step;

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:    if (batch_end) state_d = ST_SCAN_HI;
      ST_SCAN_HI: if (step && cnt_last) state_d = ST_TOP;
      ST_TOP:     if (step) state_d = ST_ZERO;
      ST_ZERO:    if (step) state_d = ST_SCAN_LO;
      ST_SCAN_LO: if (step && cnt_last) state_d = ST_LOAD;
      default:    state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    head_d      = head_q;
    travel_d    = travel_q;
    out_valid_d = out_valid_q && out_stall_i;
    if ((state_q == ST_SCAN_HI || state_q == ST_SCAN_LO) && step) begin
      cnt_d = cnt_last ? '0 : cnt_q + CntW'(1);
    end
    if (state_q == ST_LOAD && batch_end) begin
      head_d   = start_i;
      travel_d = '0;
    end else if (load_out) begin
      head_d   = target;
      travel_d = travel_next;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      head_q      <= '0;
      travel_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      head_q      <= head_d;
      travel_q    <= travel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      pos_q <= CYL_W'(target);
      mov_q <= travel_next;
      fin_q <= fin;
    end
  end

  assign in_stall_o  = (state_q != ST_LOAD);
  assign ctl_o       = ctl;
  assign out_valid_o = out_valid_q;
  assign position_o  = pos_q;
  assign movement_o  = mov_q;
  assign final_res_o = fin_q;

  `include "assert_macros.svh"

  `CSDS_ASSERT_IMP(a_scan_full_turn, (state_q == ST_SCAN_HI) && (state_d == ST_TOP), cnt_last, "high scan left before a full turn")
  `CSDS_ASSERT_NXT(a_fin_ends_batch, load_out && fin, (state_q == ST_LOAD) || (state_q == ST_SCAN_LO), "final move not in closing phase")
  `CSDS_ASSERT_IMP(a_no_load_idle, state_q == ST_LOAD, !load_out, "result produced while loading")

endmodule

@@ hw/rtl/cscan_disk_scheduler.sv @@
// Top level of the C-SCAN disk scheduler: config registers and the cell chain.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   cylinder_i, last_i
//   out      output     out_valid_o / out_stall_i position_o, movement_o, final_res_o
//   cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// Loading takes one item per cycle; each item is sorted into the cell row in place.
// After the item marked last, the schedule is emitted by turning the row around
// twice, with the top and zero moves between the two turns; a stalled output
// holds the emission whenever a move is ready.
// Reset clears every cell's valid bit at once; no clearing pass is needed.
// Input is stalled for the whole emission; a finished result waits in the output
// register while the next batch starts loading.
module cscan_disk_scheduler #(
  parameter int MaxRequests = csds_pkg::MAX_REQUESTS_DEF,
  parameter int CylBits     = csds_pkg::CYL_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [csds_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [csds_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [csds_pkg::CYL_W-1:0]      cylinder_i,
  input  logic                            last_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [csds_pkg::CYL_W-1:0]      position_o,
  output logic [csds_pkg::MOVE_W-1:0]     movement_o,
  output logic                            final_res_o
);
  import csds_pkg::*;

  localparam int C1 = (MaxRequests > 1) ? 1 : 0;

  // Config registers keep only the low CylBits bits.
  logic [CylBits-1:0] start_q, max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      max_q   <= MAX_CYL_RESET[CylBits-1:0];
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_START_POSITION: start_q <= cfg_data_i[CylBits-1:0];
        REG_MAX_CYLINDER:   max_q   <= cfg_data_i[CylBits-1:0];
        default:            start_q <= start_q;
      endcase
    end
  end

  // Clamp a request above the top cylinder to the top.
  logic [CylBits-1:0] cyl_raw, cyl;
  assign cyl_raw = cylinder_i[CylBits-1:0];
  assign cyl     = (cyl_raw > max_q) ? max_q : cyl_raw;

  logic in_accept;
  assign in_accept = in_valid_i && !in_stall_o;

  // Cell row: each cell sees its left neighbor for insertion and its right
  // neighbor for rotation; the last cell wraps to the first.
  logic [MaxRequests-1:0] vld;
  logic [MaxRequests-1:0] place;
  logic [CylBits-1:0]     val [MaxRequests];
  cell_ctl_t              ctl;

  for (genvar i = 0; i < MaxRequests; i++) begin : g_cell
    localparam int Nx = (i + 1) % MaxRequests;
    logic               pv, pp;
    logic [CylBits-1:0] pval;
    if (i == 0) begin : g_head
      assign pv   = 1'b0;
      assign pp   = 1'b0;
      assign pval = '0;
    end else begin : g_body
      assign pv   = vld[i-1];
      assign pp   = place[i-1];
      assign pval = val[i-1];
    end
    csds_cell #(
      .CylBits(CylBits)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .ins_value_i (cyl),
      .prev_valid_i(pv),
      .prev_value_i(pval),
      .prev_place_i(pp),
      .next_valid_i(vld[Nx]),
      .next_value_i(val[Nx]),
      .valid_o     (vld[i]),
      .value_o     (val[i]),
      .place_o     (place[i])
    );
  end

  // Second cell feeds the last-low check; a single-cell row has none.
  logic c1_valid;
  assign c1_valid = (MaxRequests > 1) ? vld[C1] : 1'b0;

  csds_ctrl #(
    .MaxRequests(MaxRequests),
    .CylBits    (CylBits)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_accept_i(in_accept),
    .in_last_i  (last_i),
    .full_i     (vld[MaxRequests-1]),
    .in_stall_o (in_stall_o),
    .start_i    (start_q),
    .max_i      (max_q),
    .c0_valid_i (vld[0]),
    .c0_value_i (val[0]),
    .c1_valid_i (c1_valid),
    .c1_value_i (val[C1]),
    .ctl_o      (ctl),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .position_o (position_o),
    .movement_o (movement_o),
    .final_res_o(final_res_o)
  );

  `include "assert_macros.svh"

  // While loading, the filled cells form a prefix of the row.
  `CSDS_ASSERT_IMP(a_fill_prefix, !in_stall_o, (vld & (vld + MaxRequests'(1))) == '0, "valid cells not contiguous")

endmodule

@@ test/cscan_schedule_checker.sv @@
// Checker for the C-SCAN disk scheduler: predicts service orders and compares results.
`timescale 1ns / 100ps
module cscan_schedule_checker #(
  parameter int MaxRequests = csds_pkg::MAX_REQUESTS_DEF,
  parameter int CylBits     = csds_pkg::CYL_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [csds_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [csds_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [csds_pkg::CYL_W-1:0]      cylinder_i,
  input  logic                            last_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [csds_pkg::CYL_W-1:0]      position_i,
  input  logic [csds_pkg::MOVE_W-1:0]     movement_i,
  input  logic                            final_res_i,
  output int                              pending_o,
  output int                              mismatches_o
);
  import csds_pkg::*;

  typedef struct packed {
    logic [CYL_W-1:0]  position;
    logic [MOVE_W-1:0] movement;
    logic              final_res;
  } move_t;

  localparam logic [CYL_W-1:0] CylMask = CYL_W'((32'd1 << CylBits) - 1);

  logic [CYL_W-1:0]  start_pos;
  logic [CYL_W-1:0]  top_cyl;
  logic [CYL_W-1:0]  head_cyl;
  logic [MOVE_W-1:0] travel;
  logic [CYL_W-1:0]  request_q[$];
  move_t             move_q[$];

  initial mismatches_o = 0;

  task automatic report_mismatch(input string what);
    if (mismatches_o < 50) $display("MISMATCH @%0t: %s", $time, what);
    mismatches_o++;
  endtask

  // Move the head, accumulate travel and queue the expected move.
  function automatic void add_move(input logic [CYL_W-1:0] target, input logic fin);
    logic [CYL_W-1:0] gap;
    gap = (target > head_cyl) ? target - head_cyl : head_cyl - target;
    travel = travel + MOVE_W'(gap);
    head_cyl = target;
    move_q.push_back('{position: target, movement: travel, final_res: fin});
  endfunction

  // Clamp to the top cylinder and sort in; drop once the store is full.
  function automatic void file_request(input logic [CYL_W-1:0] cyl);
    int slot;
    if (cyl > top_cyl) cyl = top_cyl;
    if (request_q.size() >= MaxRequests) return;
    slot = request_q.size();
    for (int i = 0; i < request_q.size(); i++) begin
      if (request_q[i] > cyl) begin
        slot = i;
        break;
      end
    end
    request_q.insert(slot, cyl);
  endfunction

  // Sweep up from the head, wrap over top and zero, then take the rest ascending.
  function automatic void plan_service_order();
    int n_low;
    int seen;
    n_low = 0;
    seen = 0;
    head_cyl = start_pos;
    travel = '0;
    foreach (request_q[i]) begin
      if (request_q[i] > start_pos) add_move(request_q[i], 1'b0);
      else n_low++;
    end
    add_move(top_cyl, 1'b0);
    add_move('0, n_low == 0);
    foreach (request_q[i]) begin
      if (request_q[i] <= start_pos) begin
        seen++;
        add_move(request_q[i], seen == n_low);
      end
    end
    request_q.delete();
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    move_t want;
    if (!rst_ni) begin
      start_pos = '0;
      top_cyl = MAX_CYL_RESET & CylMask;
      request_q.delete();
      move_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_START_POSITION: start_pos = cfg_data_i & CylMask;
          REG_MAX_CYLINDER:   top_cyl = cfg_data_i & CylMask;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (move_q.size() == 0) begin
          report_mismatch($sformatf("unexpected move to %0d", position_i));
        end else begin
          want = move_q.pop_front();
          if (position_i !== want.position)
            report_mismatch($sformatf("position %0d, want %0d", position_i, want.position));
          if (movement_i !== want.movement)
            report_mismatch($sformatf("movement %0d, want %0d", movement_i, want.movement));
          if (final_res_i !== want.final_res)
            report_mismatch($sformatf("final_res %0b, want %0b", final_res_i,
                                      want.final_res));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        file_request(cylinder_i & CylMask);
        if (last_i) plan_service_order();
      end
      pending_o = move_q.size();
    end
  end

endmodule

@@ test/tb_cscan_disk_scheduler.sv @@
// Testbench top for the C-SCAN disk scheduler: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb_cscan_disk_scheduler;
  import csds_pkg::*;

  localparam int HoldCycles  = 300;  // long receiver hold-off under pressure
  localparam int DrainCycles = 80;   // settle time after the last predicted move

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = REG_START_POSITION;
  logic [CFG_W-1:0]     cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic [CYL_W-1:0]     cylinder_i  = '0;
  logic                 last_i      = 1'b0;
  logic                 out_stall_i = 1'b0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic [CYL_W-1:0]     position_o;
  logic [MOVE_W-1:0]    movement_o;
  logic                 final_res_o;

  int               pending;
  int               mismatches;
  int               send_idle_pct = 0;
  int               stall_pct     = 0;
  logic             hold_go       = 1'b0;
  int               hold_cnt      = 0;
  logic [CYL_W-1:0] cur_start;
  logic [CYL_W-1:0] cur_max;
  logic [CYL_W-1:0] prev_cyl = '0;

  cscan_disk_scheduler i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cylinder_i  (cylinder_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .position_o  (position_o),
    .movement_o  (movement_o),
    .final_res_o (final_res_o)
  );

  cscan_schedule_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .cylinder_i   (cylinder_i),
    .last_i       (last_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .position_i   (position_o),
    .movement_i   (movement_o),
    .final_res_i  (final_res_o),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: hold off for a long counted stretch once pressure is requested,
  // otherwise stall at random with the phase's rate.
  always @(posedge clk_i) begin
    if (hold_go && hold_cnt < HoldCycles) begin
      out_stall_i <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Write both registers on back-to-back edges; call only while the block is idle.
  task automatic configure(input logic [CYL_W-1:0] start, input logic [CYL_W-1:0] top);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_START_POSITION;
    cfg_data_i <= start;
    @(posedge clk_i);
    cfg_idx_i  <= REG_MAX_CYLINDER;
    cfg_data_i <= top;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_start = start;
    cur_max = top;
  endtask

  // Offer one item after a random gap and hold it until the block takes it.
  // Valid stays high afterwards so that the next item can follow without a gap.
  task automatic send_item(input logic [CYL_W-1:0] cyl, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cylinder_i <= cyl;
    last_i     <= lst;
    do @(posedge clk_i); while (in_stall_o);
    prev_cyl = cyl;
  endtask

  // Drop valid, wait for every predicted move, then let the block settle.
  task automatic finish_phase();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Mostly in-range requests, some full-width values, some repeats of the
  // previous request or of the head to get duplicates and boundary hits.
  function automatic logic [CYL_W-1:0] pick_cylinder();
    case ($urandom_range(0, 3))
      0, 1:    return CYL_W'($urandom_range(0, cur_max));
      2:       return CYL_W'($urandom);
      default: return $urandom_range(0, 1) ? prev_cyl : cur_start;
    endcase
  endfunction

  task automatic run_batch(input int len);
    for (int i = 0; i < len; i++) send_item(pick_cylinder(), i == len - 1);
  endtask

  task automatic random_config();
    logic [CYL_W-1:0] top;
    case ($urandom_range(0, 4))
      0: configure($urandom_range(0, 1) ? '1 : '0, $urandom_range(0, 1) ? '1 : '0);
      1: configure(CYL_W'($urandom), '1);
      default: begin
        top = CYL_W'($urandom_range(16, 1023));
        // Let the head sit a little above the top now and then.
        configure(CYL_W'($urandom_range(0, top + 8)), top);
      end
    endcase
  endtask

  // Reconfigure before every batch; now and then a batch overflows the store.
  task automatic random_phase(input int idle, input int stall);
    int sent;
    int len;
    sent = 0;
    send_idle_pct = idle;
    stall_pct = stall;
    while (sent < 10) begin
      random_config();
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 36) : $urandom_range(1, 8);
      run_batch(len);
      finish_phase();
      sent += len;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Classic textbook queue: requests on both sides of the head.
    configure(16'd53, 16'd199);
    send_item(16'd98, 1'b0);
    send_item(16'd183, 1'b0);
    send_item(16'd37, 1'b0);
    send_item(16'd122, 1'b0);
    send_item(16'd14, 1'b0);
    send_item(16'd124, 1'b0);
    send_item(16'd65, 1'b0);
    send_item(16'd67, 1'b1);
    finish_phase();

    // Requests above the top get clamped; duplicates give zero-length moves.
    send_item(16'd250, 1'b0);
    send_item(16'd40, 1'b0);
    send_item(16'd40, 1'b0);
    send_item(16'd199, 1'b0);
    send_item(16'd0, 1'b1);
    finish_phase();

    // Head above the top: go down to the top first, then wrap.
    configure(16'hFFFF, 16'd100);
    send_item(16'd7, 1'b0);
    send_item(16'hFFFF, 1'b1);
    finish_phase();

    // Zero-size disk: everything collapses onto cylinder 0.
    configure(16'd0, 16'd0);
    send_item(16'd0, 1'b0);
    send_item(16'd1, 1'b0);
    send_item(16'hFFFF, 1'b1);
    finish_phase();

    // Full-range disk with nothing at or below the head: the wrap move ends it.
    configure(16'd0, 16'hFFFF);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h5555, 1'b0);
    send_item(16'hAAAA, 1'b0);
    send_item(16'd1, 1'b1);
    finish_phase();

    random_phase(0, 0);
    random_phase(58, 0);
    random_phase(0, 58);
    random_phase(31, 31);

    // Pressure: hold the output while an overfull batch and a second one arrive,
    // so the emission backs up and the input has to stall.
    send_idle_pct = 0;
    stall_pct = 31;
    random_config();
    hold_go <= 1'b1;
    run_batch(34);
    run_batch(4);
    finish_phase();

    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far above the slowest correct run.
  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
